[sv/chs_pkg.sv]
// Shared types and constants for the chained hash set engine.
// No dependencies; used by every other file of the block but chs_ram.
`default_nettype none
package chs_pkg;

    // Fixed field widths
    localparam int KEY_W    = 31;
    localparam int OP_W     = 2;
    localparam int BCNT_W   = 9;
    localparam int BKT_W    = 8;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_BUCKETS = 256;
    localparam int DEF_POOL_NODES  = 1024;

    localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(11);

    // Operation codes
    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture key/op, arm divider
        logic div_step;
        logic head_rd;
        logic head_cap;
        logic node_rd;
        logic node_adv;
        logic hit;
        logic free_rd;
        logic free_cap;
        logic fresh_take;
        logic set_full;
        logic ins_wr;
        logic del_unlink;
        logic del_free;
        logic clr_init;
        logic clr_step;
        logic res_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic            div_done;
        logic            clr_done;
        logic            cur_null;
        logic            key_match;
        logic            free_empty;
        logic            fresh_full;
        logic            found;
        logic            out_free;
        logic [OP_W-1:0] op;
    } t_stat;

endpackage
`default_nettype wire

[sv/chs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[sv/chs_ctrl.sv]
// Controller state machine of the chained hash set engine.
// Depends on chs_pkg; drives the datapath through t_cmd, reads t_stat.
`default_nettype none
module chs_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic [chs_pkg::OP_W-1:0] i_in_op,
    output logic                       o_in_ready,
    input  wire chs_pkg::t_stat        i_stat,
    output chs_pkg::t_cmd              o_cmd
);

    typedef enum logic [13:0] {
        S_INIT  = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_DIV   = 14'b00000000000100,
        S_HEAD  = 14'b00000000001000,
        S_HEADW = 14'b00000000010000,
        S_CHK   = 14'b00000000100000,
        S_CMP   = 14'b00000001000000,
        S_ACT   = 14'b00000010000000,
        S_FREEW = 14'b00000100000000,
        S_INS   = 14'b00001000000000,
        S_DEL2  = 14'b00010000000000,
        S_CLEAR = 14'b00100000000000,
        S_RES   = 14'b01000000000000,
        S_SPARE = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_op == chs_pkg::OP_CLEAR) begin
                        o_cmd.clr_init = 1'b1;
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_HEAD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state = S_HEADW;
            end
            S_HEADW: begin
                o_cmd.head_cap = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_stat.cur_null) begin
                    n_state = S_ACT;
                end else begin
                    o_cmd.node_rd = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.key_match) begin
                    o_cmd.hit = 1'b1;
                    n_state = S_ACT;
                end else begin
                    o_cmd.node_adv = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_ACT: begin
                n_state = S_RES;
                case (i_stat.op)
                    chs_pkg::OP_INSERT: begin
                        if (!i_stat.found) begin
                            if (!i_stat.free_empty) begin
                                o_cmd.free_rd = 1'b1;
                                n_state = S_FREEW;
                            end else if (!i_stat.fresh_full) begin
                                o_cmd.fresh_take = 1'b1;
                                n_state = S_INS;
                            end else begin
                                o_cmd.set_full = 1'b1;
                            end
                        end
                    end
                    chs_pkg::OP_DELETE: begin
                        if (i_stat.found) begin
                            o_cmd.del_unlink = 1'b1;
                            n_state = S_DEL2;
                        end
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end
            S_FREEW: begin
                o_cmd.free_cap = 1'b1;
                n_state = S_INS;
            end
            S_INS: begin
                o_cmd.ins_wr = 1'b1;
                n_state = S_RES;
            end
            S_DEL2: begin
                o_cmd.del_free = 1'b1;
                n_state = S_RES;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/chs_dp.sv]
// Datapath of the chained hash set engine: divider, chain walker, pool, RAMs.
// Depends on chs_pkg and chs_ram; controlled by chs_ctrl through t_cmd.
`default_nettype none
module chs_dp #(
    parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_NODES  = chs_pkg::DEF_POOL_NODES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire chs_pkg::t_cmd                 i_cmd,
    output chs_pkg::t_stat                     o_stat,
    input  wire logic [chs_pkg::OP_W-1:0]      i_op,
    input  wire logic [chs_pkg::KEY_W-1:0]     i_key,
    input  wire logic [chs_pkg::BCNT_W-1:0]    i_bcnt,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic                               o_found,
    output logic [chs_pkg::STATUS_W-1:0]       o_status,
    output logic [chs_pkg::BKT_W-1:0]          o_bucket
);

    localparam int BA_W  = $clog2(MAX_BUCKETS);
    localparam int NA_W  = $clog2(POOL_NODES);
    localparam int N_W   = $clog2(POOL_NODES + 1);
    localparam int DC_W  = $clog2(chs_pkg::KEY_W + 1);
    localparam int DW    = chs_pkg::BCNT_W;
    localparam logic [N_W-1:0]  NULL_NODE = N_W'(POOL_NODES);
    localparam logic [BA_W-1:0] LAST_BKT  = BA_W'(MAX_BUCKETS - 1);

    function automatic logic [N_W-1:0] clean(input logic [N_W-1:0] n);
        return (n < NULL_NODE) ? n : NULL_NODE;
    endfunction

    logic [chs_pkg::OP_W-1:0]  r_op;
    logic [chs_pkg::KEY_W-1:0] r_key, r_sh;
    logic [DW-1:0]             r_div, r_rem;
    logic [DC_W-1:0]           r_dcnt;
    logic [N_W-1:0]            r_head, r_cur, r_prev, r_next, r_new, r_free, r_fresh, r_steps;
    logic [BA_W-1:0]           r_clr;
    logic                      r_found, r_full;
    logic                      r_ovalid;

    logic [DW-1:0]  eff;
    logic [DW:0]    div_t;
    logic [BA_W-1:0] bkt_addr;

    logic [N_W-1:0]             head_rdata, link_rdata;
    logic [chs_pkg::KEY_W-1:0]  key_rdata;
    logic                       head_we, link_we, key_we;
    logic [BA_W-1:0]            head_waddr;
    logic [N_W-1:0]             head_wdata, link_wdata;
    logic [NA_W-1:0]            link_waddr, node_raddr;

    // Effective bucket count: zero acts as one, saturate at the table size
    always_comb begin
        if (i_bcnt == '0) begin
            eff = DW'(1);
        end else if (32'(i_bcnt) > MAX_BUCKETS) begin
            eff = DW'(MAX_BUCKETS);
        end else begin
            eff = i_bcnt;
        end
    end

    assign div_t    = {r_rem, r_sh[chs_pkg::KEY_W-1]};
    assign bkt_addr = BA_W'(r_rem);

    // Divider, walker and pool registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free   <= NULL_NODE;
            r_fresh  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_op    <= i_op;
                r_key   <= i_key;
                r_sh    <= i_key;
                r_div   <= eff;
                r_rem   <= '0;
                r_dcnt  <= DC_W'(chs_pkg::KEY_W);
                r_found <= 1'b0;
                r_full  <= 1'b0;
            end
            // One restoring division step per cycle
            if (i_cmd.div_step) begin
                if (div_t >= {1'b0, r_div}) begin
                    r_rem <= DW'(div_t - {1'b0, r_div});
                end else begin
                    r_rem <= div_t[DW-1:0];
                end
                r_sh   <= r_sh << 1;
                r_dcnt <= r_dcnt - DC_W'(1);
            end
            if (i_cmd.head_cap) begin
                r_head  <= clean(head_rdata);
                r_cur   <= clean(head_rdata);
                r_prev  <= NULL_NODE;
                r_steps <= '0;
            end
            // Advance along the chain
            if (i_cmd.node_adv) begin
                r_prev  <= r_cur;
                r_cur   <= clean(link_rdata);
                r_steps <= r_steps + N_W'(1);
            end
            if (i_cmd.hit) begin
                r_found <= 1'b1;
                r_next  <= clean(link_rdata);
            end
            if (i_cmd.free_cap) begin
                r_new  <= r_free;
                r_free <= clean(link_rdata);
            end
            if (i_cmd.fresh_take) begin
                r_new   <= r_fresh;
                r_fresh <= r_fresh + N_W'(1);
            end
            if (i_cmd.set_full) begin
                r_full <= 1'b1;
            end
            if (i_cmd.del_free) begin
                r_free <= r_cur;
            end
            // Clear sweep over the bucket heads
            if (i_cmd.clr_init) begin
                r_clr   <= '0;
                r_free  <= NULL_NODE;
                r_fresh <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= (r_clr == LAST_BKT) ? '0 : r_clr + BA_W'(1);
            end
            // Output register
            if (i_cmd.res_load) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload; found stays clear for a clear since load resets it
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_found  <= r_found;
            o_bucket <= (r_op == chs_pkg::OP_CLEAR) ? '0 : r_rem[chs_pkg::BKT_W-1:0];
            if (r_op == chs_pkg::OP_CLEAR) begin
                o_status <= chs_pkg::ST_DONE;
            end else if (r_op == chs_pkg::OP_INSERT && r_found) begin
                o_status <= chs_pkg::ST_PRESENT;
            end else if (r_op == chs_pkg::OP_INSERT && r_full) begin
                o_status <= chs_pkg::ST_POOL_FULL;
            end else if (r_op == chs_pkg::OP_DELETE && !r_found) begin
                o_status <= chs_pkg::ST_NOT_FOUND;
            end else begin
                o_status <= chs_pkg::ST_DONE;
            end
        end
    end

    assign o_res_valid = r_ovalid;

    // RAM write selection
    always_comb begin
        head_we    = 1'b0;
        head_waddr = bkt_addr;
        head_wdata = NULL_NODE;
        link_we    = 1'b0;
        link_waddr = r_new[NA_W-1:0];
        link_wdata = r_head;
        key_we     = i_cmd.ins_wr;
        if (i_cmd.clr_step) begin
            head_we    = 1'b1;
            head_waddr = r_clr;
        end else if (i_cmd.ins_wr) begin
            head_we    = 1'b1;
            head_wdata = r_new;
            link_we    = 1'b1;
        end else if (i_cmd.del_unlink) begin
            if (r_prev == NULL_NODE) begin
                head_we    = 1'b1;
                head_wdata = r_next;
            end else begin
                link_we    = 1'b1;
                link_waddr = r_prev[NA_W-1:0];
                link_wdata = r_next;
            end
        end else if (i_cmd.del_free) begin
            link_we    = 1'b1;
            link_waddr = r_cur[NA_W-1:0];
            link_wdata = r_free;
        end
    end

    assign node_raddr = i_cmd.free_rd ? r_free[NA_W-1:0] : r_cur[NA_W-1:0];

    chs_ram #(.WIDTH(N_W), .DEPTH(MAX_BUCKETS)) u_heads (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (bkt_addr),
        .o_rdata (head_rdata)
    );

    chs_ram #(.WIDTH(N_W), .DEPTH(POOL_NODES)) u_links (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (node_raddr),
        .o_rdata (link_rdata)
    );

    chs_ram #(.WIDTH(chs_pkg::KEY_W), .DEPTH(POOL_NODES)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_new[NA_W-1:0]),
        .i_wdata (r_key),
        .i_raddr (node_raddr),
        .o_rdata (key_rdata)
    );

    // Status toward the controller
    always_comb begin
        o_stat.div_done   = (r_dcnt == '0);
        o_stat.clr_done   = (r_clr == LAST_BKT);
        o_stat.cur_null   = (r_cur == NULL_NODE) || (r_steps == NULL_NODE);
        o_stat.key_match  = (key_rdata == r_key);
        o_stat.free_empty = (r_free == NULL_NODE);
        o_stat.fresh_full = (r_fresh == NULL_NODE);
        o_stat.found      = r_found;
        o_stat.out_free   = !r_ovalid || i_res_ready;
        o_stat.op         = r_op;
    end

endmodule
`default_nettype wire

[sv/chained_hash_set_engine.sv]
// Top level of the chained hash set engine: stream ports and configuration.
// Depends on chs_pkg, chs_ctrl, chs_dp (which holds the chs_ram instances).
`default_nettype none
// A set of 31-bit keys hashed into chains by key modulo bucket_count. Each
// command on the slave stream (tuser = operation, tdata = key) returns one
// result on the master stream. Find, insert and delete go through the
// accepting cycle, the bit-serial modulo (31 steps and a final check), the
// head read and its capture, then a chain check and a compare per chain node
// and a last chain check unless the walk ends on a hit, the action state and
// the result load. An insert that takes a fresh node adds the node write, one
// that reuses a freed node adds a free-list read before that write; a delete
// that unlinks adds the free-list write. Clear sweeps the bucket-head RAM one
// entry a cycle; the same sweep runs after reset, during which no command is
// accepted. A command is accepted while the previous result still waits in
// the output register. The user must write bucket_count over the cfg channel
// only while the block is idle; the block itself does not enforce it; issue
// a clear after changing it.
module chained_hash_set_engine #(
    parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_NODES  = chs_pkg::DEF_POOL_NODES
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [chs_pkg::IN_DATA_W-1:0]       i_s_tdata,  // key[30:0]
    input  wire logic [chs_pkg::OP_W-1:0]            i_s_tuser,  // cmd[1:0]
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // found[0], status[2:1], bucket[10:3]
    output logic [chs_pkg::OUT_DATA_W-1:0]           o_m_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [chs_pkg::BCNT_W-1:0]          i_cfg_data
);

    chs_pkg::t_cmd  cmd;
    chs_pkg::t_stat stat;

    logic [chs_pkg::BCNT_W-1:0]   r_bcnt;
    logic                         found;
    logic [chs_pkg::STATUS_W-1:0] status;
    logic [chs_pkg::BKT_W-1:0]    bucket;

    // Bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= chs_pkg::BCNT_RESET;
        end else if (i_cfg_valid) begin
            r_bcnt <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    chs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_op    (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    chs_dp #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_s_tuser),
        .i_key       (i_s_tdata[chs_pkg::KEY_W-1:0]),
        .i_bcnt      (r_bcnt),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_found     (found),
        .o_status    (status),
        .o_bucket    (bucket)
    );

    // Pack the result transaction
    assign o_m_tdata = {
        (chs_pkg::OUT_DATA_W - 1 - chs_pkg::STATUS_W - chs_pkg::BKT_W)'(0),
        bucket, status, found
    };

endmodule
`default_nettype wire

[tb/sv/chained_hash_set_engine_tb.sv]
// Self-checking testbench for chained_hash_set_engine: a directed table, then random
// command streams over several bucket counts, checked against an in-bench set model.
// Depends on chs_pkg and the RTL of the block only.
`default_nettype none
module chained_hash_set_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES   = chs_pkg::DEF_POOL_NODES;
    localparam int BUCKETS = chs_pkg::DEF_MAX_BUCKETS;
    localparam logic [10:0] NIL = 11'(NODES);

    typedef struct packed {
        logic [chs_pkg::BKT_W-1:0]    bucket;
        logic [chs_pkg::STATUS_W-1:0] status;
        logic                         found;
    } t_chs_result;

    typedef struct {
        logic [chs_pkg::OP_W-1:0]  op;
        logic [chs_pkg::KEY_W-1:0] key;
        logic                      typed;
        t_chs_result               res;
    } t_dir_row;

    // DUT signals; every DUT input is driven to a known value from time zero
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [chs_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [chs_pkg::OP_W-1:0]       s_tuser = chs_pkg::OP_FIND;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [chs_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [chs_pkg::BCNT_W-1:0]     cfg_data = '0;

    chained_hash_set_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the hash set
    logic [chs_pkg::BCNT_W-1:0] shadow_bcnt = chs_pkg::BCNT_RESET;
    logic [10:0]                shadow_heads [BUCKETS];
    logic [chs_pkg::KEY_W-1:0]  shadow_keys  [NODES];
    logic [10:0]                shadow_links [NODES];
    logic [10:0]                shadow_free;
    int unsigned                shadow_fresh;

    t_chs_result pending_results[$];
    int  mismatches = 0;
    int  sent_count = 0, seen_count = 0, full_count = 0, hit_count = 0;
    bit  sender_burst = 1'b0;
    bit  rx_burst = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_cnt = 0;
    int  stall_cnt = 0;

    function automatic void shadow_clear();
        for (int i = 0; i < BUCKETS; i++) shadow_heads[i] = NIL;
        shadow_free  = NIL;
        shadow_fresh = 0;
    endfunction

    // Apply one command to the shadow set and return the result it yields
    function automatic t_chs_result hash_set_predict(logic [chs_pkg::OP_W-1:0] op,
                                                     logic [chs_pkg::KEY_W-1:0] key);
        t_chs_result r;
        int unsigned eff, b, steps;
        logic [10:0] prv, cur, hit, nxt, n;
        r = '0;
        if (op == chs_pkg::OP_CLEAR) begin
            shadow_clear();
            return r;
        end
        eff = (shadow_bcnt == 0) ? 1 : (shadow_bcnt > BUCKETS) ? BUCKETS : shadow_bcnt;
        b = key % eff;
        r.bucket = b[7:0];
        // walk the chain
        prv = NIL; hit = NIL; steps = 0;
        cur = shadow_heads[b];
        while (cur < NIL && steps < NODES) begin
            if (shadow_keys[cur] == key) begin
                hit = cur;
                break;
            end
            prv = cur;
            cur = shadow_links[cur];
            steps++;
        end
        if (hit == NIL) prv = NIL;
        r.found = (hit != NIL);
        if (op == chs_pkg::OP_INSERT) begin
            if (r.found) begin
                r.status = chs_pkg::ST_PRESENT;
            end else begin
                if (shadow_free != NIL) begin
                    n = shadow_free;
                    shadow_free = (shadow_links[n] < NIL) ? shadow_links[n] : NIL;
                end else if (shadow_fresh < NODES) begin
                    n = 11'(shadow_fresh);
                    shadow_fresh++;
                end else begin
                    n = NIL;
                end
                if (n == NIL) begin
                    r.status = chs_pkg::ST_POOL_FULL;
                end else begin
                    shadow_keys[n]  = key;
                    shadow_links[n] = shadow_heads[b];
                    shadow_heads[b] = n;
                end
            end
        end else if (op == chs_pkg::OP_DELETE) begin
            if (!r.found) begin
                r.status = chs_pkg::ST_NOT_FOUND;
            end else begin
                nxt = (shadow_links[hit] < NIL) ? shadow_links[hit] : NIL;
                if (prv == NIL) shadow_heads[b] = nxt;
                else shadow_links[prv] = nxt;
                shadow_links[hit] = shadow_free;
                shadow_free = hit;
            end
        end
        return r;
    endfunction

    // Offer one command after a random gap; predict once the transaction is taken
    task automatic send_cmd(logic [chs_pkg::OP_W-1:0] op, logic [chs_pkg::KEY_W-1:0] key,
                            bit typed = 1'b0, t_chs_result res = '0);
        int gap, r;
        t_chs_result p;
        r = $urandom_range(0, 99);
        gap = sender_burst ? 0 : (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, key};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        p = hash_set_predict(op, key);
        pending_results.push_back(typed ? res : p);
        sent_count++;
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_bcnt(logic [chs_pkg::BCNT_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_bcnt = val;
    endtask

    // Random commands drawn mostly from a small working set of keys
    task automatic random_phase(int count);
        logic [chs_pkg::KEY_W-1:0] work[32];
        logic [chs_pkg::KEY_W-1:0] k;
        logic [chs_pkg::OP_W-1:0]  op;
        int r;
        for (int i = 0; i < 32; i++) work[i] = chs_pkg::KEY_W'($urandom);
        work[0] = '0;
        work[1] = {chs_pkg::KEY_W{1'b1}};
        for (int i = 0; i < count; i++) begin
            if (i % 120 == 60) sender_burst = ~sender_burst;
            k = ($urandom_range(0, 9) == 0) ? chs_pkg::KEY_W'($urandom)
                                            : work[$urandom_range(0, 31)];
            r = $urandom_range(0, 99);
            op = (r < 30) ? chs_pkg::OP_FIND : (r < 66) ? chs_pkg::OP_INSERT
               : (r < 98) ? chs_pkg::OP_DELETE : chs_pkg::OP_CLEAR;
            send_cmd(op, k);
        end
        sender_burst = 1'b0;
    endtask

    // Receiver: random stalls, bursts of steady ready, and a long hold on request
    always @(posedge i_clk) begin
        int r;
        if (hold_req) begin
            hold_cnt = 400;
            hold_req = 1'b0;
        end
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            m_tready <= 1'b0;
            hold_cnt--;
        end else if (stall_cnt > 0) begin
            m_tready <= 1'b0;
            stall_cnt--;
        end else if (rx_burst) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                m_tready <= 1'b1;
            end else if (r < 97) begin
                m_tready <= 1'b0;
                stall_cnt = $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                stall_cnt = $urandom_range(20, 80);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_chs_result got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[10:0];
            seen_count++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result found=%0d status=%0d bucket=%0d",
                             got.found, got.status, got.bucket);
            end else begin
                want = pending_results.pop_front();
                if (got.status == chs_pkg::ST_POOL_FULL) full_count++;
                if (got.found) hit_count++;
                if (got.found !== want.found || got.status !== want.status ||
                    got.bucket !== want.bucket) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp f=%0d s=%0d b=%0d got f=%0d s=%0d b=%0d",
                                 seen_count, want.found, want.status, want.bucket,
                                 got.found, got.status, got.bucket);
                end
            end
        end
    end

    initial begin
        #60ms;
        $display("ERROR: timeout");
        $display("chained_hash_set_engine_tb: FAIL");
        $finish;
    end

    initial begin
        t_dir_row rows[$];
        logic [chs_pkg::BCNT_W-1:0] phases[8] = '{9'd13, 9'd0, 9'd1, 9'd511, 9'd251, 9'd97,
                                                 9'd300, 9'd11};
        shadow_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset bucket count of 11
        rows.push_back('{chs_pkg::OP_FIND,   31'd0,        1,
                         '{8'd0, chs_pkg::ST_DONE, 1'b0}});
        rows.push_back('{chs_pkg::OP_INSERT, 31'd0,        1,
                         '{8'd0, chs_pkg::ST_DONE, 1'b0}});
        rows.push_back('{chs_pkg::OP_INSERT, 31'd0,        1,
                         '{8'd0, chs_pkg::ST_PRESENT, 1'b1}});
        rows.push_back('{chs_pkg::OP_FIND,   31'h7FFFFFFF, 1,
                         '{8'd1, chs_pkg::ST_DONE, 1'b0}});
        rows.push_back('{chs_pkg::OP_INSERT, 31'h7FFFFFFF, 1,
                         '{8'd1, chs_pkg::ST_DONE, 1'b0}});
        rows.push_back('{chs_pkg::OP_INSERT, 31'd11,       0, '0});
        rows.push_back('{chs_pkg::OP_INSERT, 31'd22,       0, '0});
        rows.push_back('{chs_pkg::OP_FIND,   31'd11,       0, '0});
        rows.push_back('{chs_pkg::OP_DELETE, 31'd11,       0, '0});  // middle of chain
        rows.push_back('{chs_pkg::OP_DELETE, 31'd22,       0, '0});  // head of chain
        rows.push_back('{chs_pkg::OP_DELETE, 31'd0,        0, '0});  // last node
        rows.push_back('{chs_pkg::OP_DELETE, 31'd0,        1,
                         '{8'd0, chs_pkg::ST_NOT_FOUND, 1'b0}});
        rows.push_back('{chs_pkg::OP_FIND,   31'h2AAAAAAA, 0, '0});
        rows.push_back('{chs_pkg::OP_INSERT, 31'h2AAAAAAA, 0, '0});
        rows.push_back('{chs_pkg::OP_INSERT, 31'h55555555, 0, '0});
        rows.push_back('{chs_pkg::OP_INSERT, 31'd5,        0, '0});  // reuses a freed node
        rows.push_back('{chs_pkg::OP_FIND,   31'h55555555, 0, '0});
        rows.push_back('{chs_pkg::OP_CLEAR,  31'h7FFFFFFF, 1,
                         '{8'd0, chs_pkg::ST_DONE, 1'b0}});
        rows.push_back('{chs_pkg::OP_FIND,   31'd5,        1,
                         '{8'd5, chs_pkg::ST_DONE, 1'b0}});
        foreach (rows[i]) send_cmd(rows[i].op, rows[i].key, rows[i].typed, rows[i].res);
        random_phase(100);

        // Fill the pool past its size, with one long receiver hold along the way
        write_bcnt(9'd256);
        send_cmd(chs_pkg::OP_CLEAR, '0);
        for (int i = 0; i < 1040; i++) begin
            if (i == 200) hold_req = 1'b1;
            if (i == 500) rx_burst = 1'b1;
            if (i == 700) rx_burst = 1'b0;
            send_cmd(chs_pkg::OP_INSERT, chs_pkg::KEY_W'($urandom));
        end
        for (int i = 0; i < 20; i++) send_cmd(chs_pkg::OP_DELETE, chs_pkg::KEY_W'(i));
        random_phase(40);

        // Walk several bucket counts; one change is left without a clear
        foreach (phases[p]) begin
            write_bcnt(phases[p]);
            if (phases[p] != 9'd97) send_cmd(chs_pkg::OP_CLEAR, chs_pkg::KEY_W'($urandom));
            random_phase(60);
        end

        drain();
        repeat (300) @(posedge i_clk);
        $display("Covered %0d commands over %0d bucket counts: %0d hits, %0d pool-full inserts.",
                 sent_count, 10, hit_count, full_count);
        $display("Checked %0d results, %0d mismatches.", seen_count, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("chained_hash_set_engine_tb: PASS");
        end else begin
            $display("chained_hash_set_engine_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
